>>> hdl/ajs_pkg.sv
// Shared types and codes for the arm jog sequencer.
// Holds the transaction structs, operation/mode/command codes and reset levels.
// No dependencies.
`default_nettype none

package ajs_pkg;

    // Coordinate width, fixed by the telemetry field widths
    localparam int COORD_BITS = 16;
    localparam int GAP_BITS   = 10;
    localparam int CMD_BITS   = 4;
    localparam int OP_BITS    = 3;
    localparam int PHASE_BITS = 2;
    localparam int CFG_BITS   = 10;

    // Configuration register indexes
    localparam logic CFG_OPEN_LEVEL   = 1'b0;
    localparam logic CFG_CLOSED_LEVEL = 1'b1;

    localparam logic [GAP_BITS-1:0] OPEN_LEVEL_RST   = 10'd215;
    localparam logic [GAP_BITS-1:0] CLOSED_LEVEL_RST = 10'd115;

    // Operation codes of an input transaction
    localparam logic [OP_BITS-1:0] OP_TELEMETRY = 3'd0;
    localparam logic [OP_BITS-1:0] OP_MOVE      = 3'd1;
    localparam logic [OP_BITS-1:0] OP_WRIST     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_GRIPPER   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_HOME      = 3'd4;

    // Motion modes
    localparam logic [OP_BITS-1:0] MODE_IDLE    = 3'd0;
    localparam logic [OP_BITS-1:0] MODE_MOVE    = 3'd1;
    localparam logic [OP_BITS-1:0] MODE_WRIST   = 3'd2;
    localparam logic [OP_BITS-1:0] MODE_GRIPPER = 3'd3;
    localparam logic [OP_BITS-1:0] MODE_HOME    = 3'd4;

    // Gripper phases
    localparam logic [PHASE_BITS-1:0] PH_OPENING = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_CLOSING = 2'd1;

    // Jog commands
    localparam logic [CMD_BITS-1:0] JOG_NONE      = 4'd0;
    localparam logic [CMD_BITS-1:0] JOG_X_POS     = 4'd1;
    localparam logic [CMD_BITS-1:0] JOG_X_NEG     = 4'd2;
    localparam logic [CMD_BITS-1:0] JOG_Y_POS     = 4'd3;
    localparam logic [CMD_BITS-1:0] JOG_Y_NEG     = 4'd4;
    localparam logic [CMD_BITS-1:0] JOG_Z_POS     = 4'd5;
    localparam logic [CMD_BITS-1:0] JOG_Z_NEG     = 4'd6;
    localparam logic [CMD_BITS-1:0] JOG_WRIST_CW  = 4'd7;
    localparam logic [CMD_BITS-1:0] JOG_WRIST_CCW = 4'd8;
    localparam logic [CMD_BITS-1:0] JOG_OPEN      = 4'd9;
    localparam logic [CMD_BITS-1:0] JOG_CLOSE     = 4'd10;

    // Wrist half-turn limits
    localparam logic signed [COORD_BITS-1:0] WRIST_HALF = 16'sd180;
    localparam logic signed [COORD_BITS-1:0] WRIST_MAX  = 16'sd360;
    localparam logic signed [COORD_BITS-1:0] WRIST_MIN  = 16'sd0;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  operation;
        coord_t              pos_x;
        coord_t              pos_y;
        coord_t              pos_z;
        coord_t              wrist_angle;
        logic [GAP_BITS-1:0] gripper_gap;
        coord_t              goal_x;
        coord_t              goal_y;
        coord_t              goal_z;
        logic                turn_clockwise;
    } in_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] jog_command;
        logic                busy_res;
    } out_t;

    // Jog toward goal on one axis (0 x, 1 y, 2 z); none when matched
    function automatic logic [CMD_BITS-1:0] axis_cmd(input logic [1:0] axis,
                                                     input coord_t cur,
                                                     input coord_t goal);
        logic [CMD_BITS-1:0] cmd;
        cmd = JOG_NONE;
        if (cur != goal) begin
            case (axis)
                2'd0:    cmd = (cur < goal) ? JOG_X_POS : JOG_X_NEG;
                2'd1:    cmd = (cur < goal) ? JOG_Y_POS : JOG_Y_NEG;
                2'd2:    cmd = (cur < goal) ? JOG_Z_POS : JOG_Z_NEG;
                default: cmd = JOG_NONE;
            endcase
        end
        return cmd;
    endfunction

endpackage

`default_nettype wire

>>> hdl/axis_jog_sequencer.sv
// Arm jog sequencer top level: state update and next-command selection.
// Depends on ajs_pkg for transaction structs, codes and the axis compare.
//
//  channel | ports                       | moves
//  --------+-----------------------------+------------------------------------
//  input   | s_valid s_ready s_data      | telemetry report or start request
//  result  | m_valid m_ready m_data      | next jog command and busy flag
//  config  | cfg_we cfg_index cfg_data   | gripper open / closed levels
//
// One transaction per cycle: the state update and command pick are one pass
// of compares into the state and result registers.
// The result register holds a finished result while the next transaction is
// taken whenever m_ready is high; a stalled result stops intake.
// Reset (synchronous, active low) clears the positions, home, goals and mode
// and loads the default gripper levels. No clearing pass.
`default_nettype none

module axis_jog_sequencer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire ajs_pkg::in_t                 s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output ajs_pkg::out_t                     m_data,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [ajs_pkg::CFG_BITS-1:0] cfg_data
);

    // Configuration
    logic [ajs_pkg::GAP_BITS-1:0] open_level_reg;
    logic [ajs_pkg::GAP_BITS-1:0] closed_level_reg;

    // Tracked state
    ajs_pkg::coord_t              cur_x_reg, cur_y_reg, cur_z_reg, cur_wrist_reg;
    logic [ajs_pkg::GAP_BITS-1:0] cur_gap_reg;
    ajs_pkg::coord_t              home_reg   [3];
    logic                         home_latched_reg;
    ajs_pkg::coord_t              target_reg [3];
    ajs_pkg::coord_t              wrist_goal_reg;
    logic [ajs_pkg::OP_BITS-1:0]    mode_reg;
    logic [ajs_pkg::PHASE_BITS-1:0] phase_reg;

    // Next values
    ajs_pkg::coord_t              cur_x_next, cur_y_next, cur_z_next, cur_wrist_next;
    logic [ajs_pkg::GAP_BITS-1:0] cur_gap_next;
    ajs_pkg::coord_t              home_next   [3];
    logic                         home_latched_next;
    ajs_pkg::coord_t              target_next [3];
    ajs_pkg::coord_t              wrist_goal_next;
    logic [ajs_pkg::OP_BITS-1:0]    mode_next;
    logic [ajs_pkg::PHASE_BITS-1:0] phase_next;
    logic [ajs_pkg::CMD_BITS-1:0]   cmd_next;

    // Result register
    logic          m_valid_reg;
    ajs_pkg::out_t m_data_reg;

    logic accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Apply the transaction, then pick the next jog of the active motion
    always_comb begin
        logic [ajs_pkg::OP_BITS-1:0]    mode_mid;
        logic [ajs_pkg::PHASE_BITS-1:0] phase_mid;
        logic [ajs_pkg::CMD_BITS-1:0]   ax_cmd [3];
        ajs_pkg::coord_t                cur_pos [3];
        logic [ajs_pkg::CMD_BITS-1:0]   seq_cmd;
        logic [ajs_pkg::PHASE_BITS-1:0] seq_phase;

        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        cur_z_next        = cur_z_reg;
        cur_wrist_next    = cur_wrist_reg;
        cur_gap_next      = cur_gap_reg;
        home_next         = home_reg;
        home_latched_next = home_latched_reg;
        target_next       = target_reg;
        wrist_goal_next   = wrist_goal_reg;
        mode_mid          = mode_reg;
        phase_mid         = phase_reg;

        if (s_data.operation == ajs_pkg::OP_TELEMETRY) begin
            cur_x_next     = s_data.pos_x;
            cur_y_next     = s_data.pos_y;
            cur_z_next     = s_data.pos_z;
            cur_wrist_next = s_data.wrist_angle;
            cur_gap_next   = s_data.gripper_gap;
            // First report after reset is home
            if (!home_latched_reg) begin
                home_next[0]      = s_data.pos_x;
                home_next[1]      = s_data.pos_y;
                home_next[2]      = s_data.pos_z;
                home_latched_next = 1'b1;
            end
        end else if (mode_reg == ajs_pkg::MODE_IDLE) begin
            // Start request; ignored while a motion runs
            case (s_data.operation)
                ajs_pkg::OP_MOVE: begin
                    mode_mid       = ajs_pkg::MODE_MOVE;
                    target_next[0] = s_data.goal_x;
                    target_next[1] = s_data.goal_y;
                    target_next[2] = s_data.goal_z;
                end
                ajs_pkg::OP_WRIST: begin
                    mode_mid = ajs_pkg::MODE_WRIST;
                    if (s_data.turn_clockwise) begin
                        wrist_goal_next = (cur_wrist_reg < ajs_pkg::WRIST_MAX) ?
                                          cur_wrist_reg + ajs_pkg::WRIST_HALF :
                                          ajs_pkg::WRIST_MAX;
                    end else begin
                        wrist_goal_next = (cur_wrist_reg > ajs_pkg::WRIST_MIN) ?
                                          cur_wrist_reg - ajs_pkg::WRIST_HALF :
                                          ajs_pkg::WRIST_MIN;
                    end
                end
                ajs_pkg::OP_GRIPPER: mode_mid = ajs_pkg::MODE_GRIPPER;
                ajs_pkg::OP_HOME:    mode_mid = ajs_pkg::MODE_HOME;
                default:             mode_mid = ajs_pkg::MODE_IDLE;
            endcase
            phase_mid = '0;
        end

        // Per-axis jog toward the goal of the active axis motion
        cur_pos[0] = cur_x_next;
        cur_pos[1] = cur_y_next;
        cur_pos[2] = cur_z_next;
        for (int a = 0; a < 3; a++) begin
            ax_cmd[a] = ajs_pkg::axis_cmd(2'(a), cur_pos[a],
                            (mode_mid == ajs_pkg::MODE_MOVE) ? target_next[a]
                                                             : home_next[a]);
        end

        seq_cmd   = ajs_pkg::JOG_NONE;
        seq_phase = '0;
        case (mode_mid)
            ajs_pkg::MODE_MOVE: begin
                // X, Y, Z order: lowest unmatched axis at or after the phase
                for (int a = 2; a >= 0; a--) begin
                    if (2'(a) >= phase_mid && ax_cmd[a] != ajs_pkg::JOG_NONE) begin
                        seq_cmd   = ax_cmd[a];
                        seq_phase = 2'(a);
                    end
                end
            end
            ajs_pkg::MODE_HOME: begin
                // Z, Y, X order: phase counts up from Z
                for (int a = 0; a < 3; a++) begin
                    if (2'(2 - a) >= phase_mid && ax_cmd[a] != ajs_pkg::JOG_NONE) begin
                        seq_cmd   = ax_cmd[a];
                        seq_phase = 2'(2 - a);
                    end
                end
            end
            ajs_pkg::MODE_WRIST: begin
                if (cur_wrist_next != wrist_goal_next) begin
                    seq_cmd = (cur_wrist_next < wrist_goal_next) ?
                              ajs_pkg::JOG_WRIST_CW : ajs_pkg::JOG_WRIST_CCW;
                end
            end
            ajs_pkg::MODE_GRIPPER: begin
                if (phase_mid == ajs_pkg::PH_OPENING &&
                    cur_gap_next < open_level_reg) begin
                    seq_cmd   = ajs_pkg::JOG_OPEN;
                    seq_phase = ajs_pkg::PH_OPENING;
                end else if (cur_gap_next > closed_level_reg) begin
                    seq_cmd   = ajs_pkg::JOG_CLOSE;
                    seq_phase = ajs_pkg::PH_CLOSING;
                end
            end
            default: seq_cmd = ajs_pkg::JOG_NONE;
        endcase

        // Drop to idle once nothing is left to jog
        cmd_next   = seq_cmd;
        mode_next  = (seq_cmd == ajs_pkg::JOG_NONE) ? ajs_pkg::MODE_IDLE : mode_mid;
        phase_next = (seq_cmd == ajs_pkg::JOG_NONE) ? '0 : seq_phase;
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_level_reg   <= ajs_pkg::OPEN_LEVEL_RST;
            closed_level_reg <= ajs_pkg::CLOSED_LEVEL_RST;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            cur_z_reg        <= '0;
            cur_wrist_reg    <= '0;
            cur_gap_reg      <= '0;
            home_reg         <= '{default: '0};
            home_latched_reg <= 1'b0;
            target_reg       <= '{default: '0};
            wrist_goal_reg   <= '0;
            mode_reg         <= ajs_pkg::MODE_IDLE;
            phase_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ajs_pkg::CFG_OPEN_LEVEL:   open_level_reg   <= cfg_data;
                    ajs_pkg::CFG_CLOSED_LEVEL: closed_level_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                cur_z_reg        <= cur_z_next;
                cur_wrist_reg    <= cur_wrist_next;
                cur_gap_reg      <= cur_gap_next;
                home_reg         <= home_next;
                home_latched_reg <= home_latched_next;
                target_reg       <= target_next;
                wrist_goal_reg   <= wrist_goal_next;
                mode_reg         <= mode_next;
                phase_reg        <= phase_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.jog_command <= cmd_next;
            m_data_reg.busy_res    <= (cmd_next != ajs_pkg::JOG_NONE);
        end
    end

    // Idle always carries phase zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == ajs_pkg::MODE_IDLE |-> phase_reg == '0)
        else $error("idle mode with nonzero phase");

    // Axis motions never park past the last axis; gripper has two phases
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == ajs_pkg::MODE_MOVE || mode_reg == ajs_pkg::MODE_HOME ||
         mode_reg == ajs_pkg::MODE_GRIPPER) |-> phase_reg != 2'd3)
        else $error("motion phase out of range");

    // Busy flag matches a pending jog
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.busy_res == (m_data.jog_command != ajs_pkg::JOG_NONE)))
        else $error("busy flag disagrees with jog command");

    // A result is busy exactly when a motion remains active
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> (m_data.busy_res == (mode_reg != ajs_pkg::MODE_IDLE)))
        else $error("busy flag disagrees with motion mode");

    // Home latches only on a telemetry transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(home_latched_reg) |->
            $past(accept && s_data.operation == ajs_pkg::OP_TELEMETRY))
        else $error("home latched without telemetry");

    // A stalled result freezes the motion state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(mode_reg) && $stable(phase_reg))
        else $error("motion state moved while result stalled");

endmodule

`default_nettype wire

>>> tb/tb_axis_jog_sequencer.sv
// Self-checking testbench for axis_jog_sequencer: directed, level, backpressure and random tests.
// Keeps its own jog predictor and checks each result transaction in order against it.
// Depends on ajs_pkg (hdl/ajs_pkg.sv) and the axis_jog_sequencer RTL.
module tb_axis_jog_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import ajs_pkg::*;

    // Operation codes the block must treat as no-ops
    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_C = 3'd7;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready;
    out_t                m_data;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    // Predicted arm and sequencer state
    coord_t              arm_x, arm_y, arm_z, arm_wrist;
    logic [GAP_BITS-1:0] arm_gap;
    coord_t              home_at [3];
    bit                  home_set;
    coord_t              target_at [3];
    coord_t              wrist_aim;
    logic [OP_BITS-1:0]  mode_q;
    logic [PHASE_BITS-1:0] phase_q;
    logic [GAP_BITS-1:0] open_lvl, closed_lvl;

    out_t jog_expected_q [$];
    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;

    axis_jog_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Walk the motion until it yields a jog or finishes; finishing drops back to idle
    function automatic logic [CMD_BITS-1:0] next_jog();
        logic [CMD_BITS-1:0] cmd;
        logic [1:0]          ax;
        coord_t              here, goal;
        int                  g;
        for (g = 0; g < 4; g++) begin
            if (mode_q == MODE_MOVE || mode_q == MODE_HOME) begin
                if (phase_q > 2'd2)
                    break;
                ax   = (mode_q == MODE_MOVE) ? phase_q : 2'd2 - phase_q;
                here = (ax == 2'd0) ? arm_x : ((ax == 2'd1) ? arm_y : arm_z);
                goal = (mode_q == MODE_MOVE) ? target_at[ax] : home_at[ax];
                if (here != goal) begin
                    case (ax)
                        2'd0:    cmd = (here < goal) ? JOG_X_POS : JOG_X_NEG;
                        2'd1:    cmd = (here < goal) ? JOG_Y_POS : JOG_Y_NEG;
                        default: cmd = (here < goal) ? JOG_Z_POS : JOG_Z_NEG;
                    endcase
                    return cmd;
                end
                phase_q = phase_q + 2'd1;
            end else if (mode_q == MODE_WRIST) begin
                if (arm_wrist != wrist_aim)
                    return (arm_wrist < wrist_aim) ? JOG_WRIST_CW : JOG_WRIST_CCW;
                break;
            end else if (mode_q == MODE_GRIPPER) begin
                if (phase_q == PH_OPENING) begin
                    if (arm_gap < open_lvl)
                        return JOG_OPEN;
                    phase_q = PH_CLOSING;
                end else begin
                    if (arm_gap > closed_lvl)
                        return JOG_CLOSE;
                    break;
                end
            end else begin
                break;
            end
        end
        mode_q  = MODE_IDLE;
        phase_q = '0;
        return JOG_NONE;
    endfunction

    // Apply one accepted transaction to the predicted state and return its result
    function automatic out_t predict_jog(input in_t t);
        out_t r;
        if (t.operation == OP_TELEMETRY) begin
            arm_x     = t.pos_x;
            arm_y     = t.pos_y;
            arm_z     = t.pos_z;
            arm_wrist = t.wrist_angle;
            arm_gap   = t.gripper_gap;
            if (!home_set) begin
                home_at[0] = arm_x;
                home_at[1] = arm_y;
                home_at[2] = arm_z;
                home_set   = 1'b1;
            end
        end else if (t.operation <= OP_HOME && mode_q == MODE_IDLE) begin
            mode_q  = t.operation;
            phase_q = '0;
            if (t.operation == OP_MOVE) begin
                target_at[0] = t.goal_x;
                target_at[1] = t.goal_y;
                target_at[2] = t.goal_z;
            end else if (t.operation == OP_WRIST) begin
                if (t.turn_clockwise)
                    wrist_aim = (arm_wrist < WRIST_MAX) ? arm_wrist + WRIST_HALF : WRIST_MAX;
                else
                    wrist_aim = (arm_wrist > WRIST_MIN) ? arm_wrist - WRIST_HALF : WRIST_MIN;
            end
        end
        r.jog_command = next_jog();
        r.busy_res    = (r.jog_command != JOG_NONE);
        return r;
    endfunction

    function automatic coord_t small_coord();
        return coord_t'(int'($urandom_range(0, 8)) - 4);
    endfunction

    // Mostly hit the aim or land next to it, sometimes anywhere
    function automatic coord_t pick_coord(input coord_t aim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return aim;
            4:          return aim + coord_t'(1);
            5:          return aim - coord_t'(1);
            6, 7:       return small_coord();
            8:          return coord_t'($urandom);
            default:    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic in_t make_telemetry(input coord_t x, input coord_t y, input coord_t z,
                                           input coord_t w, input logic [GAP_BITS-1:0] g);
        in_t t;
        t.operation      = OP_TELEMETRY;
        t.pos_x          = x;
        t.pos_y          = y;
        t.pos_z          = z;
        t.wrist_angle    = w;
        t.gripper_gap    = g;
        t.goal_x         = coord_t'($urandom);
        t.goal_y         = coord_t'($urandom);
        t.goal_z         = coord_t'($urandom);
        t.turn_clockwise = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic in_t make_request(input logic [OP_BITS-1:0] op, input coord_t gx,
                                         input coord_t gy, input coord_t gz, input logic cw);
        in_t t;
        t.operation      = op;
        t.pos_x          = coord_t'($urandom);
        t.pos_y          = coord_t'($urandom);
        t.pos_z          = coord_t'($urandom);
        t.wrist_angle    = coord_t'($urandom);
        t.gripper_gap    = GAP_BITS'($urandom_range(0, 1023));
        t.goal_x         = gx;
        t.goal_y         = gy;
        t.goal_z         = gz;
        t.turn_clockwise = cw;
        return t;
    endfunction

    // Telemetry steered toward whatever the motion in progress is waiting for
    function automatic in_t random_telemetry();
        coord_t              aim [3];
        coord_t              w_aim;
        logic [GAP_BITS-1:0] g_aim;
        logic [GAP_BITS-1:0] g;
        int                  i;
        for (i = 0; i < 3; i++) begin
            if (mode_q == MODE_MOVE)
                aim[i] = target_at[i];
            else if (mode_q == MODE_HOME)
                aim[i] = home_at[i];
            else
                aim[i] = small_coord();
        end
        if (mode_q == MODE_WRIST)
            w_aim = wrist_aim;
        else
            w_aim = $urandom_range(0, 2) == 0 ? WRIST_MAX : small_coord();
        if (mode_q == MODE_GRIPPER)
            g_aim = (phase_q == PH_OPENING) ? open_lvl : closed_lvl;
        else
            g_aim = GAP_BITS'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0, 1, 2: g = g_aim;
            3:       g = open_lvl;
            4:       g = closed_lvl;
            5:       g = closed_lvl + GAP_BITS'(1);
            6:       g = open_lvl - GAP_BITS'(1);
            7:       g = GAP_BITS'($urandom_range(0, 1023));
            8:       g = '0;
            default: g = '1;
        endcase
        return make_telemetry(pick_coord(aim[0]), pick_coord(aim[1]), pick_coord(aim[2]),
                              pick_coord(w_aim), g);
    endfunction

    function automatic in_t random_request();
        logic [OP_BITS-1:0] op;
        op = OP_BITS'($urandom_range(OP_MOVE, OP_HOME));
        return make_request(op, pick_coord(small_coord()), pick_coord(small_coord()),
                            pick_coord(small_coord()), 1'($urandom_range(0, 1)));
    endfunction

    // Offer one transaction, idling first at the current rate; predict on acceptance
    task automatic send_item(input in_t item);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        jog_expected_q.push_back(predict_jog(item));
    endtask

    // Hold off the input until every expected result is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (jog_expected_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_level(input logic idx, input logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == CFG_OPEN_LEVEL)
            open_lvl = val;
        else
            closed_lvl = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Field extremes, every operation and the corner cases, at full rate
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // return home before any telemetry: home is zero, already there
        send_item(make_request(OP_HOME, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_request(OP_SPARE_A, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_request(OP_SPARE_B, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_item(make_request(OP_SPARE_C, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        // first report latches home, second must not
        send_item(make_telemetry(16'sh8000, 16'sh7FFF, -16'sd1, 16'sh7FFF, 10'd1023));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 10'd0));
        // move to far corners, with a request ignored while busy
        send_item(make_request(OP_MOVE, 16'sh7FFF, 16'sh8000, 16'sd0, 1'b1));
        send_item(make_request(OP_WRIST, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_item(make_telemetry(16'sh7FFF, 16'sd0, 16'sd5, 16'sd0, 10'd0));
        send_item(make_telemetry(16'sh7FFF, 16'sh8000, 16'sd5, 16'sd0, 10'd0));
        send_item(make_telemetry(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 10'd0));
        // home runs Z, Y, X
        send_item(make_request(OP_HOME, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_telemetry(16'sh7FFF, 16'sh8000, -16'sd1, 16'sd0, 10'd0));
        send_item(make_telemetry(16'sh7FFF, 16'sh7FFF, -16'sd1, 16'sd0, 10'd0));
        send_item(make_telemetry(16'sh8000, 16'sh7FFF, -16'sd1, 16'sd360, 10'd0));
        // wrist clamps at 360 and at 0, then real half turns
        send_item(make_request(OP_WRIST, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd0));
        send_item(make_request(OP_WRIST, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd359, 10'd0));
        send_item(make_request(OP_WRIST, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd539, 10'd0));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd1, 10'd0));
        send_item(make_request(OP_WRIST, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, -16'sd179, 10'd0));
        // gripper: open, close, done; then a move whose goal is already met
        send_item(make_request(OP_GRIPPER, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd215));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd115));
        send_item(make_request(OP_MOVE, 16'sd0, 16'sd0, 16'sd0, 1'b0));
    endtask

    // Extreme gripper levels, then back to the defaults
    task automatic test_levels();
        drain_results();
        write_level(CFG_OPEN_LEVEL, 10'd0);
        write_level(CFG_CLOSED_LEVEL, 10'd1023);
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd500));
        send_item(make_request(OP_GRIPPER, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        drain_results();
        write_level(CFG_OPEN_LEVEL, 10'd1023);
        write_level(CFG_CLOSED_LEVEL, 10'd0);
        send_item(make_request(OP_GRIPPER, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd1022));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd1023));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd1));
        send_item(make_telemetry(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd0));
        drain_results();
        write_level(CFG_OPEN_LEVEL, OPEN_LEVEL_RST);
        write_level(CFG_CLOSED_LEVEL, CLOSED_LEVEL_RST);
    endtask

    // Long receiver hold-off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 60;
        repeat (24) send_item(mode_q == MODE_IDLE ? random_request() : random_telemetry());
        drain_results();
        repeat (10) send_item(mode_q == MODE_IDLE ? random_request() : random_telemetry());
    endtask

    // Well-formed request/telemetry sequences with some noise, under fresh levels
    task automatic run_random(input int n_items, input int s_pct, input int r_pct);
        int  sent;
        int  roll;
        logic [CFG_BITS-1:0] lvl;
        in_t item;
        drain_results();
        lvl = CFG_BITS'($urandom_range(1, 1023));
        write_level(CFG_OPEN_LEVEL, lvl);
        if ($urandom_range(0, 3) == 0)
            write_level(CFG_CLOSED_LEVEL, CFG_BITS'($urandom_range(0, 1023)));
        else
            write_level(CFG_CLOSED_LEVEL, CFG_BITS'($urandom_range(0, lvl - CFG_BITS'(1))));
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (mode_q == MODE_IDLE) begin
                if (roll < 40) begin
                    item = random_request();
                    sent++;
                end else if (roll < 95) begin
                    item = random_telemetry();
                    sent++;
                end else begin
                    item = make_request(OP_BITS'(OP_SPARE_A + $urandom_range(0, 2)),
                                        small_coord(), small_coord(), small_coord(),
                                        1'($urandom_range(0, 1)));
                end
            end else begin
                if (roll < 85) begin
                    item = random_telemetry();
                    sent++;
                end else if (roll < 93) begin
                    item = random_request();
                end else begin
                    item = make_request(OP_BITS'(OP_SPARE_A + $urandom_range(0, 2)),
                                        small_coord(), small_coord(), small_coord(),
                                        1'($urandom_range(0, 1)));
                end
            end
            send_item(item);
        end
    endtask

    task automatic test_random_traffic();
        run_random(85, 0, 0);
        run_random(85, 57, 0);
        run_random(85, 0, 57);
        run_random(85, 22, 22);
    endtask

    // Receiver: counted hold-off first, else random stalls at the current rate
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready   = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_jog
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (jog_expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: jog %0d busy %0b",
                             m_data.jog_command, m_data.busy_res);
            end else begin
                want = jog_expected_q.pop_front();
                if (m_data.jog_command !== want.jog_command ||
                    m_data.busy_res !== want.busy_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: jog exp %0d got %0d, busy exp %0b got %0b",
                                 want.jog_command, m_data.jog_command,
                                 want.busy_res, m_data.busy_res);
                end
            end
        end
    end

    initial begin
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_OPEN_LEVEL;
        cfg_data   = '0;
        aresetn    = 1'b0;
        // predictor matches the block's reset state
        arm_x      = '0;
        arm_y      = '0;
        arm_z      = '0;
        arm_wrist  = '0;
        arm_gap    = '0;
        home_at    = '{default: '0};
        target_at  = '{default: '0};
        home_set   = 1'b0;
        wrist_aim  = '0;
        mode_q     = MODE_IDLE;
        phase_q    = '0;
        open_lvl   = OPEN_LEVEL_RST;
        closed_lvl = CLOSED_LEVEL_RST;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_levels();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (5) @(posedge aclk);

        if (mismatches == 0 && jog_expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
